[src/ckpf_pkg.sv]
// Shared constants, register codes and types for the color key pixel filter.
// No dependencies; every other file of the block imports this package.
package ckpf_pkg;

  // Field widths
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned THR_W     = 9;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Datapath widths: sum of three channels, one square, squared distance
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned SQ_W   = 16;
  localparam int unsigned DIST_W = 18;

  // Divide by three as multiply by 683 and shift right by 11 (exact below 2048)
  localparam int unsigned GRAY_SHIFT = 11;
  localparam int unsigned PROD_W     = SUM_W + GRAY_SHIFT;
  localparam logic [PROD_W-1:0] GRAY_RECIP = PROD_W'(683);

  // Key modes
  localparam logic [MODE_W-1:0] MODE_POP     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_COLOR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  key_mode;
    logic [COLOR_W-1:0] key_color;
    logic [COLOR_W-1:0] replacement_color;
    logic [THR_W-1:0]   distance_threshold;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_end;
  } px_t;

endpackage

[src/ckpf_in_if.sv]
// Input pixel channel: valid/ready handshake with one RGB pixel and frame flag.
// Depends on ckpf_pkg for the channel width.
interface ckpf_in_if;
  import ckpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic              frame_end_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output frame_end_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input frame_end_in, output ready);
endinterface

[src/ckpf_out_if.sv]
// Result pixel channel: valid/ready handshake with one RGB pixel and frame flag.
// Depends on ckpf_pkg for the channel width.
interface ckpf_out_if;
  import ckpf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              frame_end_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input frame_end_out, output ready);
endinterface

[src/ckpf_cfg_regs.sv]
// Configuration register file of the color key pixel filter.
// Depends on ckpf_pkg for register indexes and the cfg_t bundle.
module ckpf_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ckpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckpf_pkg::COLOR_W-1:0]   cfg_wdata,
  output ckpf_pkg::cfg_t                 cfg
);
  import ckpf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_KEY_MODE:   cfg_nxt.key_mode           = cfg_wdata[MODE_W-1:0];
        REG_KEY_COLOR:  cfg_nxt.key_color          = cfg_wdata;
        REG_REPL_COLOR: cfg_nxt.replacement_color  = cfg_wdata;
        REG_THRESHOLD:  cfg_nxt.distance_threshold = cfg_wdata[THR_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[src/color_key_pixel_filter.sv]
// Color key pixel filter: one RGB pixel in, one pixel out, in a four-stage pipeline.
// Depends on ckpf_pkg, ckpf_in_if, ckpf_out_if and ckpf_cfg_regs.
//
// The filter takes one pixel per clock while its input is ready and computes each
// result in order: absolute differences and the channel sum, then the three squares,
// the squared threshold and the divide-by-three product, then the distance sum and
// gray value, then the compare and select into the output register. The squares
// stage sets the pipeline depth. Back-pressure stalls each stage only when the one
// after it is full, so bubbles are squeezed out and sustained throughput stays at
// one pixel per clock whenever the sink is ready. Configuration registers take
// effect for pixels that transfer after the write; write them only while idle.
// Mode pop keeps pixels strictly closer than the threshold and grays the rest with
// (r+g+b)/3, mode remove does the opposite, mode replace writes the replacement
// color where the distance is at most the threshold, and the unused mode passes
// pixels through unchanged. The end-of-frame flag travels with its pixel.
module color_key_pixel_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  ckpf_in_if.sink                        in_ch,
  ckpf_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [ckpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ckpf_pkg::COLOR_W-1:0]   cfg_wdata
);
  import ckpf_pkg::*;

  cfg_t cfg;

  ckpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Stage valid bits and stall chain
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !out_vld_r || out_ch.ready;
  assign rdy3 = !s3_vld_r || rdy4;
  assign rdy2 = !s2_vld_r || rdy3;
  assign rdy1 = !s1_vld_r || rdy2;
  assign in_ch.ready = rdy1;

  // Stage 1: differences and channel sum
  px_t               s1_px_r, s1_px_nxt;
  logic [CHAN_W-1:0] s1_dr_r, s1_dg_r, s1_db_r;
  logic [CHAN_W-1:0] s1_dr_nxt, s1_dg_nxt, s1_db_nxt;
  logic [SUM_W-1:0]  s1_sum_r, s1_sum_nxt;
  logic [CHAN_W-1:0] key_r, key_g, key_b;

  assign key_r = cfg.key_color[2*CHAN_W +: CHAN_W];
  assign key_g = cfg.key_color[CHAN_W +: CHAN_W];
  assign key_b = cfg.key_color[0 +: CHAN_W];

  always_comb begin
    s1_px_nxt.red       = in_ch.red_in;
    s1_px_nxt.green     = in_ch.green_in;
    s1_px_nxt.blue      = in_ch.blue_in;
    s1_px_nxt.frame_end = in_ch.frame_end_in;
    s1_dr_nxt = (in_ch.red_in > key_r) ? (in_ch.red_in - key_r) : (key_r - in_ch.red_in);
    s1_dg_nxt = (in_ch.green_in > key_g) ? (in_ch.green_in - key_g)
                                         : (key_g - in_ch.green_in);
    s1_db_nxt = (in_ch.blue_in > key_b) ? (in_ch.blue_in - key_b)
                                        : (key_b - in_ch.blue_in);
    s1_sum_nxt = SUM_W'(in_ch.red_in) + SUM_W'(in_ch.green_in) + SUM_W'(in_ch.blue_in);
  end

  // Stage 2: squares, squared threshold, reciprocal product
  px_t               s2_px_r;
  logic [SQ_W-1:0]   s2_sqr_r, s2_sqg_r, s2_sqb_r;
  logic [SQ_W-1:0]   s2_sqr_nxt, s2_sqg_nxt, s2_sqb_nxt;
  logic [DIST_W-1:0] s2_t2_r, s2_t2_nxt;
  logic [PROD_W-1:0] s2_prod_r, s2_prod_nxt;

  always_comb begin
    s2_sqr_nxt  = SQ_W'(s1_dr_r) * SQ_W'(s1_dr_r);
    s2_sqg_nxt  = SQ_W'(s1_dg_r) * SQ_W'(s1_dg_r);
    s2_sqb_nxt  = SQ_W'(s1_db_r) * SQ_W'(s1_db_r);
    s2_t2_nxt   = DIST_W'(cfg.distance_threshold) * DIST_W'(cfg.distance_threshold);
    s2_prod_nxt = PROD_W'(s1_sum_r) * GRAY_RECIP;
  end

  // Stage 3: squared distance and gray value
  px_t               s3_px_r;
  logic [DIST_W-1:0] s3_d2_r, s3_d2_nxt;
  logic [DIST_W-1:0] s3_t2_r;
  logic [CHAN_W-1:0] s3_gray_r, s3_gray_nxt;

  always_comb begin
    s3_d2_nxt   = DIST_W'(s2_sqr_r) + DIST_W'(s2_sqg_r) + DIST_W'(s2_sqb_r);
    s3_gray_nxt = s2_prod_r[GRAY_SHIFT +: CHAN_W];
  end

  // Stage 4: compare and select into the output register
  px_t  out_px_r, out_px_nxt;
  logic near_lt, near_le;

  assign near_lt = s3_d2_r < s3_t2_r;
  assign near_le = s3_d2_r <= s3_t2_r;

  always_comb begin
    out_px_nxt = s3_px_r;
    case (cfg.key_mode)
      MODE_POP: begin
        if (!near_lt) begin
          out_px_nxt.red   = s3_gray_r;
          out_px_nxt.green = s3_gray_r;
          out_px_nxt.blue  = s3_gray_r;
        end
      end
      MODE_REMOVE: begin
        if (near_lt) begin
          out_px_nxt.red   = s3_gray_r;
          out_px_nxt.green = s3_gray_r;
          out_px_nxt.blue  = s3_gray_r;
        end
      end
      MODE_REPLACE: begin
        if (near_le) begin
          out_px_nxt.red   = cfg.replacement_color[2*CHAN_W +: CHAN_W];
          out_px_nxt.green = cfg.replacement_color[CHAN_W +: CHAN_W];
          out_px_nxt.blue  = cfg.replacement_color[0 +: CHAN_W];
        end
      end
      default: out_px_nxt = s3_px_r;
    endcase
  end

  // Advance valid bits where the next stage has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1) s1_vld_r  <= in_ch.valid;
      if (rdy2) s2_vld_r  <= s1_vld_r;
      if (rdy3) s3_vld_r  <= s2_vld_r;
      if (rdy4) out_vld_r <= s3_vld_r;
    end
  end

  // Load payload only on a transfer into the stage; hold it otherwise
  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      s1_px_r  <= s1_px_nxt;
      s1_dr_r  <= s1_dr_nxt;
      s1_dg_r  <= s1_dg_nxt;
      s1_db_r  <= s1_db_nxt;
      s1_sum_r <= s1_sum_nxt;
    end
    if (rdy2 && s1_vld_r) begin
      s2_px_r   <= s1_px_r;
      s2_sqr_r  <= s2_sqr_nxt;
      s2_sqg_r  <= s2_sqg_nxt;
      s2_sqb_r  <= s2_sqb_nxt;
      s2_t2_r   <= s2_t2_nxt;
      s2_prod_r <= s2_prod_nxt;
    end
    if (rdy3 && s2_vld_r) begin
      s3_px_r   <= s2_px_r;
      s3_d2_r   <= s3_d2_nxt;
      s3_t2_r   <= s2_t2_r;
      s3_gray_r <= s3_gray_nxt;
    end
    if (rdy4 && s3_vld_r) begin
      out_px_r <= out_px_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.red_out       = out_px_r.red;
  assign out_ch.green_out     = out_px_r.green;
  assign out_ch.blue_out      = out_px_r.blue;
  assign out_ch.frame_end_out = out_px_r.frame_end;

  // Stage 2 payload fingerprint for the hold check
  logic [SQ_W-1:0] s2_d2_check;
  assign s2_d2_check = s2_sqr_r ^ s2_sqg_r ^ s2_sqb_r;

  // An empty output register never blocks the input
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input stalled while output register is empty");

  // A stalled middle stage keeps its item
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_vld_r && !rdy3) |=> (s2_vld_r && $stable(s2_d2_check)))
    else $error("stage 2 lost or changed a stalled item");

  // Pop mode passes near pixels unchanged
  a_pop_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy4 && s3_vld_r && cfg.key_mode == MODE_POP && near_lt)
      |=> (out_ch.valid && out_ch.red_out == $past(s3_px_r.red)))
    else $error("pop mode altered a near pixel");

  // Replace mode writes the replacement color on near pixels
  a_replace: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy4 && s3_vld_r && cfg.key_mode == MODE_REPLACE && near_le)
      |=> (out_ch.blue_out == $past(cfg.replacement_color[CHAN_W-1:0])))
    else $error("replace mode missed a near pixel");

  // The frame flag leaves with its own pixel
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy4 && s3_vld_r) |=> (out_ch.frame_end_out == $past(s3_px_r.frame_end)))
    else $error("frame end flag separated from its pixel");

endmodule
